// ----- hw/rtl/tcw_pkg.sv -----
// Shared constants, codes and transaction types of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);
  localparam int ROW_W       = $clog2(ROWS + 1);
  localparam int COL_W       = $clog2(COLUMNS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, 8'h00};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } tcw_op_t;

  typedef struct packed {
    logic              scroll;
    logic              clear;
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } tcw_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scrolled;
    logic [7:0]       cchar;
    logic [7:0]       cattr;
  } tcw_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer_core.sv -----
// A put or read transaction passes the command queue, the back end's fetch and execute
// steps and the result queue, which drives the result ports; the back end takes one
// transaction at a time. A scroll adds a row-copy sweep through the store port.
// A clear adds a blanking sweep.
// Reset: synchronous; a blanking pass over all CELL_COUNT (2000) cells follows, during which
// up to two transactions are queued and full then holds high.
`default_nettype none

module text_console_writer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] char_code,
  input  wire logic [3:0] bg_color,
  input  wire logic [3:0] fg_color,
  input  wire logic [4:0] read_row,
  input  wire logic [6:0] read_col,
  output logic            empty,
  input  wire logic       pop,
  output logic [4:0]      cursor_row,
  output logic [6:0]      cursor_col,
  output logic            did_scroll,
  output logic [7:0]      cell_char,
  output logic [7:0]      cell_attr
);

  tcw_pkg::tcw_cmd_t cmd_in, cmd_head;
  tcw_pkg::tcw_res_t res;
  logic              q_push, cmd_pop, cmd_empty;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .operation  (operation),
    .char_code  (char_code),
    .bg_color   (bg_color),
    .fg_color   (fg_color),
    .read_row   (read_row),
    .read_col   (read_col),
    .q_full     (full),
    .q_push     (q_push),
    .cmd        (cmd_in)
  );

  tcw_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign cursor_row = 5'(res.row);
  assign cursor_col = 7'(res.col);
  assign did_scroll = res.scrolled;
  assign cell_char  = res.cchar;
  assign cell_attr  = res.cattr;

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_front.sv -----
// Front end: accepts items, tracks the cursor and classifies each item into a command.
`default_nettype none

module tcw_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [1:0]       operation,
  input  wire logic [7:0]       char_code,
  input  wire logic [3:0]       bg_color,
  input  wire logic [3:0]       fg_color,
  input  wire logic [4:0]       read_row,
  input  wire logic [6:0]       read_col,
  input  wire logic             q_full,
  output logic                  q_push,
  output tcw_pkg::tcw_cmd_t     cmd
);

  logic [tcw_pkg::ROW_W-1:0]  row, row_next;
  logic [tcw_pkg::COL_W-1:0]  col, col_next;
  logic [tcw_pkg::ROW_W-1:0]  r1, r2;
  logic [tcw_pkg::COL_W-1:0]  c1, c2;
  logic                       wrap, scr, newline, rd_ok;
  logic [tcw_pkg::ADDR_W-1:0] waddr, raddr;

  always_comb begin
    wrap    = col >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    r1      = wrap ? tcw_pkg::ROW_W'(row + 1'b1) : row;
    c1      = wrap ? '0 : col;
    scr     = r1 >= tcw_pkg::ROW_W'(tcw_pkg::ROWS);
    r2      = scr ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : r1;
    c2      = scr ? '0 : c1;
    newline = char_code == tcw_pkg::NEWLINE_CODE;
    waddr   = tcw_pkg::ADDR_W'(r2 * tcw_pkg::COLUMNS + c2);
    raddr   = tcw_pkg::ADDR_W'(read_row * tcw_pkg::COLUMNS + read_col);
    rd_ok   = (read_row < tcw_pkg::ROWS) && (read_col < tcw_pkg::COLUMNS);

    row_next   = row;
    col_next   = col;
    cmd.scroll = 1'b0;
    cmd.clear  = 1'b0;
    cmd.wr     = 1'b0;
    cmd.rd     = 1'b0;
    case (tcw_pkg::tcw_op_t'(operation))
      tcw_pkg::OP_PUT: begin
        cmd.scroll = scr;
        cmd.wr     = !newline;
        row_next   = newline ? tcw_pkg::ROW_W'(r2 + 1'b1) : r2;
        col_next   = newline ? '0 : tcw_pkg::COL_W'(c2 + 1'b1);
      end
      tcw_pkg::OP_CLEAR: begin
        cmd.clear = 1'b1;
        row_next  = '0;
        col_next  = '0;
      end
      tcw_pkg::OP_READ: begin
        cmd.rd = rd_ok;
      end
      default: begin
      end
    endcase
    cmd.addr = cmd.wr ? waddr : raddr;
    cmd.data = {bg_color, fg_color, char_code};
    cmd.row  = row_next;
    cmd.col  = col_next;
  end

  assign q_push = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (q_push) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_cmd_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module tcw_cmd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tcw_pkg::tcw_cmd_t din,
  output logic                   full,
  input  wire logic              pop,
  output tcw_pkg::tcw_cmd_t      dout,
  output logic                   empty
);

  tcw_pkg::tcw_cmd_t          slots [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wptr, rptr;
  logic [tcw_pkg::QCNT_W-1:0] count;
  logic                       do_push, do_pop;

  assign full    = count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                : tcw_pkg::QPTR_W'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                : tcw_pkg::QPTR_W'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= tcw_pkg::QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= tcw_pkg::QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_back.sv -----
// Back end: screen store, clear and scroll sweeps, command execution and result queue.
`default_nettype none

module tcw_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_pkg::tcw_cmd_t cmd_head,
  input  wire logic              cmd_empty,
  output logic                   cmd_pop,
  input  wire logic              pop,
  output logic                   empty,
  output tcw_pkg::tcw_res_t      res
);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_CLEAR  = 5'b00100,
    S_SCROLL = 5'b01000,
    S_EXEC   = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [tcw_pkg::CNT_W-1:0]  cnt, cnt_next;
  tcw_pkg::tcw_cmd_t          cur, cur_next;
  logic                       pend, pend_next;
  logic                       pend_copy, pend_copy_next;
  logic [tcw_pkg::ADDR_W-1:0] pend_addr, pend_addr_next;

  logic [15:0]                mem [tcw_pkg::CELL_COUNT];
  logic                       we;
  logic [tcw_pkg::ADDR_W-1:0] waddr, raddr;
  logic [15:0]                wdata, rdata;

  tcw_pkg::tcw_res_t          rq [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0] rq_wptr, rq_rptr;
  logic [tcw_pkg::QCNT_W-1:0] rq_count;
  logic                       res_full, res_push, res_pop;
  tcw_pkg::tcw_res_t          res_in;

  assign res_full = rq_count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);
  assign empty    = rq_count == '0;
  assign res_pop  = pop && !empty;
  assign res      = rq[rq_rptr];

  always_comb begin
    res_in.row      = cur.row;
    res_in.col      = cur.col;
    res_in.scrolled = cur.scroll;
    res_in.cchar    = cur.rd ? rdata[7:0] : 8'h00;
    res_in.cattr    = cur.rd ? rdata[15:8] : 8'h00;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_next       = cur;
    pend_next      = 1'b0;
    pend_copy_next = pend_copy;
    pend_addr_next = pend_addr;
    we             = 1'b0;
    waddr          = cnt[tcw_pkg::ADDR_W-1:0];
    wdata          = tcw_pkg::BLANK_CELL;
    raddr          = cmd_head.addr;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    case (state)
      S_INIT, S_CLEAR: begin
        we = 1'b1;
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = (state == S_INIT) ? S_IDLE : S_EXEC;
        end else begin
          cnt_next = tcw_pkg::CNT_W'(cnt + 1'b1);
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cur_next = cmd_head;
          if (cmd_head.scroll) begin
            state_next = S_SCROLL;
          end else if (cmd_head.clear) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_SCROLL: begin
        we    = pend;
        waddr = pend_addr;
        wdata = pend_copy ? rdata : tcw_pkg::BLANK_CELL;
        raddr = (cnt < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS))
                ? tcw_pkg::ADDR_W'(cnt + tcw_pkg::COLUMNS) : '0;
        if (cnt != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
          pend_next      = 1'b1;
          pend_addr_next = cnt[tcw_pkg::ADDR_W-1:0];
          pend_copy_next = cnt < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
          cnt_next       = tcw_pkg::CNT_W'(cnt + 1'b1);
        end else begin
          cnt_next   = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        raddr = cur.addr;
        waddr = cur.addr;
        wdata = cur.data;
        if (!res_full) begin
          we         = cur.wr;
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pend_copy <= pend_copy_next;
    pend_addr <= pend_addr_next;
    if (res_push) begin
      rq[rq_wptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= '0;
      pend     <= 1'b0;
      rq_wptr  <= '0;
      rq_rptr  <= '0;
      rq_count <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      if (res_push) begin
        rq_wptr <= (rq_wptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                   : tcw_pkg::QPTR_W'(rq_wptr + 1'b1);
      end
      if (res_pop) begin
        rq_rptr <= (rq_rptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                   : tcw_pkg::QPTR_W'(rq_rptr + 1'b1);
      end
      if (res_push && !res_pop) begin
        rq_count <= tcw_pkg::QCNT_W'(rq_count + 1'b1);
      end else if (res_pop && !res_push) begin
        rq_count <= tcw_pkg::QCNT_W'(rq_count - 1'b1);
      end
    end
  end

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !empty)
    else $error("pushed result not visible");

  a_scroll_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && cnt == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) |=> state == S_EXEC)
    else $error("scroll sweep did not hand over to execution");

  a_clear_pure: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!cur.wr && !cur.rd && !cur.scroll))
    else $error("clear transaction carries a cell access");

  a_exec_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !res_full) |=> state == S_IDLE)
    else $error("execution stalled with room in the result queue");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the text console writer core.
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    tcw_op_t    op;
    logic [7:0] code;
    logic [3:0] back;
    logic [3:0] fore;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } console_item_t;

  class console_scoreboard;
    logic [15:0]  cells[CELL_COUNT];
    int unsigned  cur_row;
    int unsigned  cur_col;
    tcw_res_t     pending[$];
    int           errors;

    function new();
      blank_screen();
      cur_row = 0;
      cur_col = 0;
      errors  = 0;
    endfunction

    function void blank_screen();
      foreach (cells[i]) cells[i] = BLANK_CELL;
    endfunction

    function void scroll_screen();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = BLANK_CELL;
    endfunction

    function void note_item(console_item_t it);
      tcw_res_t    want;
      int unsigned idx;
      want = '0;
      case (it.op)
        OP_PUT: begin
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            cur_col = 0;
            scroll_screen();
            want.scrolled = 1'b1;
          end
          if (it.code == NEWLINE_CODE) begin
            cur_row++;
            cur_col = 0;
          end else begin
            idx = cur_row * COLUMNS + cur_col;
            if (idx < CELL_COUNT) cells[idx] = {it.back, it.fore, it.code};
            cur_col++;
          end
        end
        OP_CLEAR: begin
          blank_screen();
          cur_row = 0;
          cur_col = 0;
        end
        OP_READ: begin
          if (it.rrow < ROWS && it.rcol < COLUMNS) begin
            idx = it.rrow * COLUMNS + it.rcol;
            want.cchar = cells[idx][7:0];
            want.cattr = cells[idx][15:8];
          end
        end
        default: ;
      endcase
      want.row = cur_row[ROW_W-1:0];
      want.col = cur_col[COL_W-1:0];
      pending.push_back(want);
    endfunction

    function void report_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(tcw_res_t seen);
      tcw_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                   $time, seen.row, seen.col);
        return;
      end
      want = pending.pop_front();
      report_field("cursor_row", want.row, seen.row);
      report_field("cursor_col", want.col, seen.col);
      report_field("did_scroll", want.scrolled, seen.scrolled);
      report_field("cell_char", want.cchar, seen.cchar);
      report_field("cell_attr", want.cattr, seen.cattr);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] operation;
  logic [7:0] char_code;
  logic [3:0] bg_color;
  logic [3:0] fg_color;
  logic [4:0] read_row;
  logic [6:0] read_col;
  logic       empty;
  logic       pop;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       did_scroll;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;

  console_scoreboard board;
  bit                calm_push;
  bit                calm_pop;

  text_console_writer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .char_code  (char_code),
    .bg_color   (bg_color),
    .fg_color   (fg_color),
    .read_row   (read_row),
    .read_col   (read_col),
    .empty      (empty),
    .pop        (pop),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .did_scroll (did_scroll),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic console_item_t mk_item(tcw_op_t op, int code, int back, int fore,
                                            int rrow, int rcol);
    console_item_t it;
    it.op   = op;
    it.code = 8'(code);
    it.back = 4'(back);
    it.fore = 4'(fore);
    it.rrow = 5'(rrow);
    it.rcol = 7'(rcol);
    return it;
  endfunction

  // mode 0: short lines, mode 1: long wrapping text, mode 2: reads and clears
  function automatic console_item_t random_item(int mode);
    console_item_t it;
    int            r;
    int            nl_odds;
    r        = $urandom_range(0, 99);
    it       = mk_item(OP_PUT, $urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 127));
    nl_odds  = (mode == 0) ? 6 : (mode == 1) ? 70 : 8;
    case (mode)
      0: it.op = (r < 80) ? OP_PUT : (r < 95) ? OP_READ : (r < 96) ? OP_CLEAR : OP_NONE;
      1: it.op = (r < 85) ? OP_PUT : (r < 98) ? OP_READ : OP_NONE;
      default: it.op = (r < 45) ? OP_PUT : (r < 85) ? OP_READ : (r < 91) ? OP_CLEAR : OP_NONE;
    endcase
    if (it.op == OP_PUT && $urandom_range(1, nl_odds) == 1) it.code = NEWLINE_CODE;
    if (it.op == OP_READ) begin
      r = $urandom_range(0, 99);
      if (r < 45 && board.cur_row < ROWS) begin
        it.rrow = 5'(board.cur_row);
        it.rcol = 7'($urandom_range(0, COLUMNS - 1));
      end else if (r < 90) begin
        it.rrow = 5'($urandom_range(0, ROWS - 1));
        it.rcol = 7'($urandom_range(0, COLUMNS - 1));
      end
    end
    return it;
  endfunction

  task automatic send_item(console_item_t it);
    int gap;
    gap = pick_gap(calm_push);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       = 1'b1;
    operation  = it.op;
    char_code  = it.code;
    bg_color   = it.back;
    fg_color   = it.fore;
    read_row   = it.rrow;
    read_col   = it.rcol;
    do @(posedge clk); while (full);
    board.note_item(it);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_result('{row: cursor_row, col: cursor_col, scrolled: did_scroll,
                           cchar: cell_char, cattr: cell_attr});
  end

  initial begin
    int gap;
    int n;
    pop = 1'b0;
    n   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n % 120 == 0) calm_pop = ($urandom_range(0, 3) == 0);
      gap = pick_gap(calm_pop);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      n++;
      @(negedge clk);
    end
  end

  initial begin
    #25_000_000;
    $display("text_console_writer_core test failed");
    $finish;
  end

  initial begin
    console_item_t directed[$];
    int            mode;
    board      = new();
    calm_push  = 1'b0;
    calm_pop   = 1'b0;
    rst        = 1'b1;
    push       = 1'b0;
    operation  = OP_NONE;
    char_code  = '0;
    bg_color   = '0;
    fg_color   = '0;
    read_row   = '0;
    read_col   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, ROWS - 1, COLUMNS - 1));
    directed.push_back(mk_item(OP_PUT, 255, 15, 15, 31, 127));
    directed.push_back(mk_item(OP_PUT, 0, 0, 0, 0, 0));
    directed.push_back(mk_item(OP_PUT, 65, 10, 5, 21, 42));
    directed.push_back(mk_item(OP_READ, 0, 15, 15, 0, 0));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, 1));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, 2));
    directed.push_back(mk_item(OP_PUT, NEWLINE_CODE, 3, 12, 0, 0));
    directed.push_back(mk_item(OP_PUT, NEWLINE_CODE, 12, 3, 0, 0));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, ROWS, 0));
    directed.push_back(mk_item(OP_READ, 255, 15, 15, 31, 127));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, COLUMNS));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, ROWS - 1, COLUMNS));
    directed.push_back(mk_item(OP_NONE, 255, 15, 15, 31, 127));
    directed.push_back(mk_item(OP_CLEAR, 255, 15, 15, 31, 127));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0));
    directed.push_back(mk_item(OP_NONE, 0, 0, 0, 0, 0));
    directed.push_back(mk_item(OP_PUT, 126, 5, 10, 0, 0));
    directed.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);

    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) mode = $urandom_range(0, 2);
      if (n % 150 == 0) calm_push = ($urandom_range(0, 3) == 0);
      send_item(random_item(mode));
    end
    push = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("text_console_writer_core test passed");
    end else begin
      $display("text_console_writer_core test failed");
    end
    $finish;
  end

endmodule
